FILE: design/chol_pkg.sv
package chol_pkg;

    localparam int MaxDim = 64;
    localparam int IdxW = 6;
    localparam int AddrW = 2 * IdxW;
    localparam int DimW = 7;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOT_PD = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [IdxW-1:0]    row_index;
        logic [IdxW-1:0]    col_index;
        logic signed [31:0] element_value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_ROWINIT, S_RDA, S_MAC_RD, S_MAC_WAIT, S_MAC_ACC,
        S_REST, S_SQRT, S_DIV, S_WRITE, S_RDL, S_RDL_WAIT, S_OUT
    } t_state;

    // Request from sequencer to the shared root/divide unit
    typedef struct packed {
        logic               start;
        logic               is_sqrt;
        logic signed [63:0] operand;
        logic signed [31:0] divisor;
    } t_unit_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] result;
    } t_unit_rsp;

endpackage

FILE: design/chol_unit.sv
module chol_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  chol_pkg::t_unit_req i_req,
    output chol_pkg::t_unit_rsp o_rsp
);
    import chol_pkg::*;

    // Shared radix-2 unit: restoring square root or restoring division,
    // one result bit per cycle.
    logic        r_busy, n_busy;
    logic        r_sqrt, n_sqrt;
    logic        r_neg, n_neg;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_num, n_num;
    logic [63:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic        r_done, n_done;

    logic [63:0] w_mag;
    logic [63:0] w_trial;
    logic [63:0] w_shrem;
    logic [63:0] w_res;
    logic signed [64:0] w_sres;

    always_comb begin
        w_mag   = '0;
        w_trial = '0;
        w_shrem = '0;
        w_res   = '0;
        n_busy = r_busy;
        n_sqrt = r_sqrt;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_num  = r_num;
        n_quo  = r_quo;
        n_den  = r_den;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_sqrt = i_req.is_sqrt;
            n_rem  = '0;
            n_quo  = '0;
            n_den  = i_req.divisor;
            if (i_req.is_sqrt) begin
                // radicand * 2^16, radicand < 2^47 fits
                n_num = {i_req.operand[47:0], 16'd0};
                n_cnt = 7'd32;
                n_neg = 1'b0;
            end else begin
                w_mag = i_req.operand[63] ? (64'd0 - i_req.operand) : i_req.operand;
                n_num = {w_mag[47:0], 16'd0};
                n_cnt = 7'd64;
                n_neg = i_req.operand[63];
            end
        end else if (r_busy) begin
            if (r_sqrt) begin
                w_shrem = {r_rem[61:0], r_num[63:62]};
                w_trial = {r_quo[61:0], 2'b01};
                n_num = {r_num[61:0], 2'b00};
                if (w_shrem >= w_trial) begin
                    n_rem = w_shrem - w_trial;
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = w_shrem;
                    n_quo = {r_quo[62:0], 1'b0};
                end
            end else begin
                w_shrem = {r_rem[62:0], r_num[63]};
                n_num = {r_num[62:0], 1'b0};
                if (w_shrem >= {32'd0, r_den}) begin
                    n_rem = w_shrem - {32'd0, r_den};
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = w_shrem;
                    n_quo = {r_quo[62:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_sqrt <= n_sqrt;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_quo  <= n_quo;
        r_den  <= n_den;
    end

    // Division: apply sign and saturate the quotient; a root passes through unchanged
    always_comb begin
        w_sres = '0;
        o_rsp.done = r_done;
        if (r_sqrt) begin
            o_rsp.result = r_quo[31:0];
        end else begin
            w_sres = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
            if (w_sres > 65'sd2147483647) begin
                o_rsp.result = 32'sh7FFFFFFF;
            end else if (w_sres < -65'sd2147483648) begin
                o_rsp.result = 32'sh80000000;
            end else begin
                o_rsp.result = w_sres[31:0];
            end
        end
    end

endmodule

FILE: design/cholesky_decomposition_top.sv
// Cholesky factor of a Q16.16 matrix, one shared multiplier plus a shared
// bit-serial root/divide unit under one sequencer.
// Write and read words go to S_OUT; a read in range passes S_RDL and S_RDL_WAIT first.
// Start clears the L store, then computes L row by row.
// One word is in flight at a time; ready drops until the result is taken.
// Reset (synchronous, active low) clears control state; L reads as zero until
// the first start, whose sweep clears the L store; A is undefined until written.
module cholesky_decomposition_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  chol_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output chol_pkg::t_out_word o_data
);
    import chol_pkg::*;

    logic [DimW-1:0] r_dim;
    logic [DimW-1:0] w_n;

    t_state r_state, n_state;
    t_in_word r_req;
    logic r_failed, n_failed;
    logic r_valid, n_valid;
    // L store holds real data only once a start has swept it
    logic r_lvalid, n_lvalid;
    t_out_word r_out, n_out;

    // Loop counters: i row, j column, k inner term
    logic [IdxW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [AddrW:0]  r_clr, n_clr;
    logic signed [63:0] r_acc, n_acc;
    logic signed [63:0] r_prod;
    logic signed [63:0] n_rest;

    // Memories
    logic signed [31:0] r_amem [0:MaxDim*MaxDim-1];
    logic signed [31:0] r_lmem [0:MaxDim*MaxDim-1];
    logic signed [31:0] r_arddata, r_lrd0, r_lrd1;
    logic [AddrW-1:0] w_ara, w_lra0, w_lra1, w_lwa;
    logic w_lwe, w_awe;
    logic signed [31:0] w_lwd;

    t_unit_req w_ureq;
    t_unit_rsp w_ursp;

    always_comb begin
        if (r_dim == '0) begin
            w_n = DimW'(1);
        end else if (r_dim > DimW'(MaxDim)) begin
            w_n = DimW'(MaxDim);
        end else begin
            w_n = r_dim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DimW'(1);
        end else if (i_cfg_we) begin
            r_dim <= i_cfg_data;
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_valid;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    chol_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ureq),
        .o_rsp   (w_ursp)
    );

    logic w_oor;
    assign w_oor = ({1'b0, i_data.row_index} >= w_n) || ({1'b0, i_data.col_index} >= w_n);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    case (t_req'(i_data.req_type))
                        REQ_START: n_state = S_CLEAR;
                        REQ_READ:  n_state = w_oor ? S_OUT : S_RDL;
                        default:   n_state = S_OUT;
                    endcase
                end
            end
            S_CLEAR:    if (r_clr[AddrW]) n_state = S_ROWINIT;
            S_ROWINIT:  n_state = S_RDA;
            S_RDA:      n_state = (r_j == '0) ? S_REST : S_MAC_RD;
            S_MAC_RD:   n_state = S_MAC_WAIT;
            S_MAC_WAIT: n_state = S_MAC_ACC;
            S_MAC_ACC:  n_state = (r_k + IdxW'(1) == r_j) ? S_REST : S_MAC_RD;
            S_REST: begin
                if (r_i == r_j && (n_rest <= 0)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = (r_i == r_j) ? S_SQRT : S_DIV;
                end
            end
            S_SQRT, S_DIV: if (w_ursp.done) n_state = S_WRITE;
            S_WRITE: begin
                if (r_i == r_j && ({1'b0, r_i} + 7'd1 == w_n)) n_state = S_OUT;
                else n_state = S_RDA;
            end
            S_RDL:      n_state = S_RDL_WAIT;
            S_RDL_WAIT: n_state = S_OUT;
            S_OUT:      n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_i = r_i; n_j = r_j; n_k = r_k; n_clr = r_clr;
        n_acc = r_acc;
        n_failed = r_failed; n_valid = r_valid; n_out = r_out;
        n_lvalid = r_lvalid;
        w_ara = {r_i, r_j};
        w_lra0 = {r_i, r_k};
        w_lra1 = {r_j, r_k};
        w_lwa = {r_i, r_j};
        w_lwe = 1'b0;
        w_lwd = w_ursp.result;
        w_awe = 1'b0;
        w_ureq = '0;
        if (r_valid && i_ready) n_valid = 1'b0;
        // A word read in S_RDA is ready in S_REST
        n_rest = $signed({{32{r_arddata[31]}}, r_arddata}) - r_acc;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_out = '{read_value: '0, status: ST_OK};
                    case (t_req'(i_data.req_type))
                        REQ_WRITE: begin
                            w_awe = !w_oor;
                            if (w_oor) n_out.status = ST_RANGE;
                        end
                        REQ_READ: if (w_oor) n_out.status = ST_RANGE;
                        REQ_START: begin
                            n_clr = '0;
                            n_lvalid = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR: begin
                w_lwe = !r_clr[AddrW];
                w_lwa = r_clr[AddrW-1:0];
                w_lwd = '0;
                n_clr = r_clr + 1'b1;
                n_i = '0; n_j = '0;
                n_failed = 1'b0;
            end
            S_RDA: begin
                n_acc = '0;
                n_k = '0;
                // fetch the pivot for a row with no inner terms
                w_lra1 = {r_j, r_j};
            end
            S_MAC_ACC: begin
                n_acc = r_acc + ((r_prod + 64'sd32768) >>> 16);
                n_k = r_k + 1'b1;
                // fetch the pivot ahead of S_REST
                w_lra1 = {r_j, r_j};
            end
            S_REST: begin
                if (r_i == r_j) begin
                    w_ureq.start = (n_rest > 0);
                    w_ureq.is_sqrt = 1'b1;
                    if (n_rest <= 0) begin
                        n_failed = 1'b1;
                        n_out.status = ST_NOT_PD;
                    end
                end else begin
                    w_ureq.start = 1'b1;
                end
                if (n_rest > 64'sh0000_4000_0000_0000)
                    w_ureq.operand = 64'sh0000_4000_0000_0000;
                else if (n_rest < -64'sh0000_4000_0000_0000)
                    w_ureq.operand = -64'sh0000_4000_0000_0000;
                else
                    w_ureq.operand = n_rest;
                w_ureq.divisor = r_lrd1;
            end
            S_WRITE: begin
                w_lwe = 1'b1;
                if (r_i == r_j) begin
                    n_i = r_i + 1'b1;
                    n_j = '0;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_RDL_WAIT: begin
                n_out.read_value = r_lvalid ? r_lrd0 : '0;
                n_out.status = r_failed ? ST_NOT_PD : ST_OK;
            end
            S_OUT: n_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_failed <= 1'b0;
            r_lvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_failed <= n_failed;
            r_lvalid <= n_lvalid;
        end
        if (i_valid && o_ready) r_req <= i_data;
        r_i <= n_i; r_j <= n_j; r_k <= n_k; r_clr <= n_clr;
        r_acc <= n_acc; r_out <= n_out;
        r_prod <= r_lrd0 * r_lrd1;
    end

    // Memory ports: A written on an in-range write accept, read by sequencer; L one write, two reads
    always_ff @(posedge i_clk) begin
        if (w_awe) r_amem[{i_data.row_index, i_data.col_index}] <= i_data.element_value;
        r_arddata <= r_amem[w_ara];
    end

    always_ff @(posedge i_clk) begin
        if (w_lwe) r_lmem[w_lwa] <= w_lwd;
        if (r_state == S_RDL) r_lrd0 <= r_lmem[{r_req.row_index, r_req.col_index}];
        else r_lrd0 <= r_lmem[w_lra0];
    end

    always_ff @(posedge i_clk) begin
        r_lrd1 <= r_lmem[w_lra1];
    end

endmodule
